// ===== hdl/vsnm_pkg.sv =====
// Shared types and constants of the six-neighbour majority filter.
package vsnm_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    // Reset value of both size registers.
    localparam logic [8:0] CFG_DIM_RESET = 9'd256;

    // A voxel becomes 1 when its six neighbours sum to more than this.
    localparam int NEIGHBOUR_THRESHOLD = 4;

    // Width of the six-neighbour sum: six full voxels at most.
    localparam int SUM_W = 11;

    // Per-voxel control carried from the read stage to the compute stage.
    typedef struct packed {
        logic       has_xp;
        logic       has_xm;
        logic       has_yp;
        logic       has_ym;
        logic       flush;
        logic       past_first;
        logic       volume_last;
        logic [7:0] voxel;
    } vsnm_s1_t;

endpackage

// ===== hdl/vsnm_ram.sv =====
// Synchronous memory with one write port and one or more registered read ports.
module vsnm_ram #(
    parameter int DEPTH  = 2,
    parameter int DATA_W = 8,
    parameter int READS  = 1
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [$clog2(DEPTH)-1:0]                waddr,
    input  logic [DATA_W-1:0]                       wdata,
    input  logic                                    re,
    input  logic [READS-1:0][$clog2(DEPTH)-1:0]     raddr,
    output logic [READS-1:0][DATA_W-1:0]            rdata
);

    logic [DATA_W-1:0]             mem [DEPTH];
    logic [READS-1:0][DATA_W-1:0]  rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            for (int i = 0; i < READS; i++) begin
                rdata_reg[i] <= mem[raddr[i]];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/vsnm_sum.sv =====
// Six-neighbour sum with edge replacement and the majority decision.
module vsnm_sum (
    input  vsnm_pkg::vsnm_s1_t s1,
    input  logic [7:0]         center,
    input  logic [7:0]         xp,
    input  logic [7:0]         xm,
    input  logic [7:0]         yp,
    input  logic [7:0]         ym,
    input  logic               zm_bit,
    output logic               filtered_bit
);

    logic [7:0]                  nxp, nxm, nyp, nym, nzp, nzm;
    logic [vsnm_pkg::SUM_W-1:0]  sum;

    always_comb begin
        // A neighbour outside the volume is replaced by the centre value.
        nxp = s1.has_xp ? xp : center;
        nxm = s1.has_xm ? xm : center;
        nyp = s1.has_yp ? yp : center;
        nym = s1.has_ym ? ym : center;
        nzp = s1.flush ? center : s1.voxel;
        nzm = s1.past_first ? {7'd0, zm_bit} : center;
        sum = vsnm_pkg::SUM_W'(nxp) + vsnm_pkg::SUM_W'(nxm) + vsnm_pkg::SUM_W'(nyp)
            + vsnm_pkg::SUM_W'(nym) + vsnm_pkg::SUM_W'(nzp) + vsnm_pkg::SUM_W'(nzm);
        filtered_bit = sum > vsnm_pkg::SUM_W'(vsnm_pkg::NEIGHBOUR_THRESHOLD);
    end

endmodule

// ===== hdl/voxel_six_neighbor_majority_filter.sv =====
// Top level of the six-neighbour majority filter over a voxel volume.
//
// Voxels enter on the s_ channel in raster order, column fastest, one slice
// after another; s_tuser set marks a flush transaction that ends the volume.
// Each position of slice z gives one filtered bit on the m_ channel, issued
// for the transaction that delivers the same position of slice z+1 (or of the
// flush pass); the last bit of the flush pass carries m_tlast. The first
// slice only fills the plane store and gives no output, and a flush while no
// slice is complete is dropped.
// The block takes one transaction every cycle unless the receiver stalls.
// Each result is registered in the memory read stage and then in the output
// register. When the receiver stalls, one result waits in the output
// register and one in the read stage; the input is then held off, so no
// result is ever dropped.
// The current and next slices sit in two banks of three replicated plane
// memories, five reads a cycle, centre included; a slice end swaps the banks
// in place of a copy. Filtered bits of the previous slice sit in a one-bit
// plane memory, with forwarding when a bit is read in the cycle it is written.
// Reset clears the counters and handshake state; the memories need no
// clearing. Sizes are written on the cfg channel, which is always ready.
module voxel_six_neighbor_majority_filter #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration writes.
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data,
    // Input voxels.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] voxel
    input  logic       s_tuser,    // [0] flush_pass
    // Filtered bits.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [0] filtered_bit, [7:1] zero
    output logic       m_tlast     // volume_last
);

    localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
    localparam int PW    = $clog2(PLANE);
    localparam int AW    = $clog2(2 * PLANE);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);

    // Configuration registers.
    logic [8:0] width_reg, height_reg;

    // Raster position and volume state.
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic          loaded_reg, loaded_next;
    logic          past_first_reg, past_first_next;
    logic          bank_reg, bank_next;

    // Read stage and output register.
    logic               s1_valid_reg;
    vsnm_pkg::vsnm_s1_t s1_reg, s1_next;
    logic [PW-1:0]      s1_idx_reg;
    logic               fwd_hit_reg, fwd_bit_reg;
    logic               out_valid_reg, out_bit_reg, out_last_reg;

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [CW-1:0] x;
    logic [RW-1:0] y;
    logic [PW-1:0] idx;
    logic [AW-1:0] cur_base, wr_base;
    logic          accept, ignore, load, result, slice_end, s1_adv;
    logic          filtered_bit;

    logic [1:0][AW-1:0] ra0, ra1;
    logic [0:0][AW-1:0] ra2;
    logic [0:0][PW-1:0] rap;
    logic [1:0][7:0]    rd0, rd1;
    logic [0:0][7:0]    rd2;
    logic [0:0][0:0]    rdp;

    assign cfg_ready = 1'b1;

    // Effective sizes: zero counts as one, larger values saturate.
    always_comb begin
        if (width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(height_reg) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(height_reg);
        end
    end

    // Counters beyond a shrunk size are held at the last column or row.
    assign x = (WW'(col_reg) < w_eff) ? col_reg : CW'(w_eff - WW'(1));
    assign y = (HW'(row_reg) < h_eff) ? row_reg : RW'(h_eff - HW'(1));
    assign idx = PW'(y) * PW'(MAX_WIDTH) + PW'(x);

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;
    assign ignore   = !loaded_reg && s_tuser;
    assign load     = accept && !loaded_reg && !s_tuser;
    assign result   = accept && loaded_reg;

    assign cur_base = bank_reg ? AW'(idx) + AW'(PLANE) : AW'(idx);
    // Loading fills the current bank; later slices fill the other one.
    assign wr_base  = (bank_reg ^ loaded_reg) ? AW'(idx) + AW'(PLANE) : AW'(idx);

    always_comb begin
        col_next        = col_reg;
        row_next        = row_reg;
        loaded_next     = loaded_reg;
        past_first_next = past_first_reg;
        bank_next       = bank_reg;
        slice_end       = 1'b0;

        if (WW'(x) + WW'(1) < w_eff) begin
            col_next = x + CW'(1);
            row_next = y;
        end else begin
            col_next = '0;
            if (HW'(y) + HW'(1) >= h_eff) begin
                slice_end = 1'b1;
                row_next  = '0;
            end else begin
                row_next = y + RW'(1);
            end
        end

        if (!loaded_reg) begin
            if (slice_end) begin
                loaded_next = 1'b1;
            end
        end else if (slice_end) begin
            if (s_tuser) begin
                loaded_next     = 1'b0;
                past_first_next = 1'b0;
            end else begin
                bank_next       = !bank_reg;
                past_first_next = 1'b1;
            end
        end

        s1_next.has_xp      = WW'(x) + WW'(1) < w_eff;
        s1_next.has_xm      = x != '0;
        s1_next.has_yp      = HW'(y) + HW'(1) < h_eff;
        s1_next.has_ym      = y != '0;
        s1_next.flush       = s_tuser;
        s1_next.past_first  = past_first_reg;
        s1_next.volume_last = slice_end && s_tuser;
        s1_next.voxel       = s_tdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= vsnm_pkg::CFG_DIM_RESET;
            height_reg     <= vsnm_pkg::CFG_DIM_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            loaded_reg     <= 1'b0;
            past_first_reg <= 1'b0;
            bank_reg       <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == vsnm_pkg::CFG_WIDTH) begin
                    width_reg <= cfg_data;
                end else if (cfg_index == vsnm_pkg::CFG_HEIGHT) begin
                    height_reg <= cfg_data;
                end
            end
            if (accept && !ignore) begin
                col_reg        <= col_next;
                row_reg        <= row_next;
                loaded_reg     <= loaded_next;
                past_first_reg <= past_first_next;
                bank_reg       <= bank_next;
            end
            if (result) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (result) begin
            s1_reg      <= s1_next;
            s1_idx_reg  <= idx;
            // The bit leaving the read stage now is written this cycle; the
            // memory would return the old one at the same entry.
            fwd_hit_reg <= s1_adv && (s1_idx_reg == idx);
            fwd_bit_reg <= filtered_bit;
        end
        if (s1_adv) begin
            out_bit_reg  <= filtered_bit;
            out_last_reg <= s1_reg.volume_last;
        end
    end

    assign ra0[0] = cur_base;
    assign ra0[1] = cur_base + AW'(1);
    assign ra1[0] = cur_base - AW'(1);
    assign ra1[1] = cur_base + AW'(MAX_WIDTH);
    assign ra2[0] = cur_base - AW'(MAX_WIDTH);
    assign rap[0] = idx;

    // Three copies of the two-bank plane store, all written with each non-flush voxel.
    vsnm_ram #(.DEPTH(2 * PLANE), .DATA_W(8), .READS(2)) u_plane0 (
        .aclk  (aclk),
        .we    (load || (result && !s_tuser)),
        .waddr (wr_base),
        .wdata (s_tdata),
        .re    (result),
        .raddr (ra0),
        .rdata (rd0)
    );

    vsnm_ram #(.DEPTH(2 * PLANE), .DATA_W(8), .READS(2)) u_plane1 (
        .aclk  (aclk),
        .we    (load || (result && !s_tuser)),
        .waddr (wr_base),
        .wdata (s_tdata),
        .re    (result),
        .raddr (ra1),
        .rdata (rd1)
    );

    vsnm_ram #(.DEPTH(2 * PLANE), .DATA_W(8), .READS(1)) u_plane2 (
        .aclk  (aclk),
        .we    (load || (result && !s_tuser)),
        .waddr (wr_base),
        .wdata (s_tdata),
        .re    (result),
        .raddr (ra2),
        .rdata (rd2)
    );

    // Filtered bits of the previous slice, rewritten in place.
    vsnm_ram #(.DEPTH(PLANE), .DATA_W(1), .READS(1)) u_prev (
        .aclk  (aclk),
        .we    (s1_adv),
        .waddr (s1_idx_reg),
        .wdata (filtered_bit),
        .re    (result),
        .raddr (rap),
        .rdata (rdp)
    );

    vsnm_sum u_sum (
        .s1           (s1_reg),
        .center       (rd0[0]),
        .xp           (rd0[1]),
        .xm           (rd1[0]),
        .yp           (rd1[1]),
        .ym           (rd2[0]),
        .zm_bit       (fwd_hit_reg ? fwd_bit_reg : rdp[0][0]),
        .filtered_bit (filtered_bit)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bit_reg};
    assign m_tlast  = out_last_reg;

endmodule
